/* src/dvn_pkg.sv */
// Shared types, widths and constants of the dynamic volume normalizer.
package dvn_pkg;

    // Block length at which a block ends even without a marked last sample.
    localparam int MAX_BLOCK = 4096;

    localparam int SAMPLE_W = 24;                     // Q3.20 sample
    localparam int GAIN_W   = 24;                     // Q8.16 gain
    localparam int LIMIT_W  = 23;                     // Q3.20 clip magnitude
    localparam int RATE_W   = 16;                     // Q0.16 recovery coefficient
    localparam int SUM_W    = 36;                     // level accumulator
    localparam int CNT_W    = $clog2(MAX_BLOCK + 1);  // holds 1 .. MAX_BLOCK
    localparam int FRAC_W   = 20;                     // fraction bits of a sample
    localparam int GFRAC_W  = 16;                     // fraction bits of the gain
    localparam int PROD_W   = SAMPLE_W + GAIN_W;      // |sample| * gain
    localparam int MAG_W    = PROD_W - GFRAC_W;       // scaled magnitude
    localparam int BPROD_W  = SUM_W + RATE_W;         // level error * rate
    localparam int DIV_W    = 32;                     // divider operand width
    localparam int DCNT_W   = 6;                      // divider step counter
    localparam int CFG_W    = LIMIT_W;                // widest register

    // Quotient bits produced by the clip and the recovery divisions.
    localparam logic [DCNT_W-1:0] CLIP_STEPS  = DCNT_W'(GAIN_W);
    localparam logic [DCNT_W-1:0] BLOCK_STEPS = DCNT_W'(DIV_W);

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]  GAIN_MAX    = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(655);
    localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);

    // Configuration register indexes.
    typedef enum logic {
        CFG_CLIP_LIMIT    = 1'b0,
        CFG_RECOVERY_RATE = 1'b1
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // take the input beat
        logic mul;         // register |sample| * gain
        logic scale;       // round, clip decision, level sum, count
        logic clip_sat;    // clip with gain quotient beyond range
        logic clip_load;   // start gain / magnitude division
        logic clip_upd;    // gain from the clip quotient
        logic div_step;    // one divider step
        logic bmag;        // level error magnitude and sign
        logic bmul;        // level error * recovery rate
        logic bload;       // start division by block length
        logic bupd;        // apply recovery delta, clear block state
        logic emit;        // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clipped;
        logic sat;
        logic blk_end;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

/* src/dvn_divider.sv */
// Shared restoring divider, one quotient bit per cycle in which i_step is high.
module dvn_divider
    import dvn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [DIV_W-1:0]  i_rem_init,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    input  logic [DCNT_W-1:0] i_steps,
    output logic [DIV_W-1:0]  o_quotient,
    output logic              o_done
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dd;
    logic [DIV_W-1:0]  r_dsr;
    logic [DIV_W-1:0]  r_quo;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W:0]    w_trial;
    logic              w_fit;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign w_trial = {r_rem, r_dd[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_steps;
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Operand registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem_init;
            r_dd  <= i_dividend;
            r_dsr <= i_divisor;
            r_quo <= '0;
        end else if (i_step && r_cnt != '0) begin
            r_rem <= w_fit ? DIV_W'(w_trial - {1'b0, r_dsr}) : w_trial[DIV_W-1:0];
            r_dd  <= {r_dd[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = (r_cnt == '0);

endmodule

/* src/dvn_ctrl.sv */
// Controller state machine that sequences one sample through the datapath.
module dvn_ctrl
    import dvn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MUL   = 10'b00_0000_0010,
        ST_SCALE = 10'b00_0000_0100,
        ST_CLIP  = 10'b00_0000_1000,
        ST_CDIV  = 10'b00_0001_0000,
        ST_BMAG  = 10'b00_0010_0000,
        ST_BMUL  = 10'b00_0100_0000,
        ST_BLOAD = 10'b00_1000_0000,
        ST_BDIV  = 10'b01_0000_0000,
        ST_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_after_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A block end goes through the recovery update before the beat is sent.
    assign w_after_clip = i_status.blk_end ? ST_BMAG : ST_EMIT;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_CLIP;
            end
            ST_CLIP: begin
                if (!i_status.clipped) begin
                    n_state = w_after_clip;
                end else if (i_status.sat) begin
                    o_cmd.clip_sat = 1'b1;
                    n_state        = w_after_clip;
                end else begin
                    o_cmd.clip_load = 1'b1;
                    n_state         = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (i_status.div_done) begin
                    o_cmd.clip_upd = 1'b1;
                    n_state        = w_after_clip;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_BMAG: begin
                o_cmd.bmag = 1'b1;
                n_state    = ST_BMUL;
            end
            ST_BMUL: begin
                o_cmd.bmul = 1'b1;
                n_state    = ST_BLOAD;
            end
            ST_BLOAD: begin
                o_cmd.bload = 1'b1;
                n_state     = ST_BDIV;
            end
            ST_BDIV: begin
                if (i_status.div_done) begin
                    o_cmd.bupd = 1'b1;
                    n_state    = ST_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/dvn_datapath.sv */
// Datapath: gain multiply, clipping, level accumulation, recovery and output register.
module dvn_datapath
    import dvn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [SAMPLE_W-1:0] i_in_data,
    input  logic                i_in_last,
    input  logic                i_out_ready,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [SAMPLE_W-1:0] o_out_data,
    output logic                o_out_clip,
    output logic                o_out_last
);

    logic [LIMIT_W-1:0]  r_clip_limit;
    logic [RATE_W-1:0]   r_rate;
    logic [GAIN_W-1:0]   r_gain;
    logic [SUM_W-1:0]    r_level_sum;
    logic [CNT_W-1:0]    r_count;

    logic                r_neg;
    logic [SAMPLE_W-1:0] r_amag;
    logic                r_last;
    logic                r_end;
    logic [PROD_W-1:0]   r_prod;
    logic [MAG_W-1:0]    r_m;
    logic                r_clipped;
    logic [SAMPLE_W-1:0] r_res;
    logic                r_bneg;
    logic [SUM_W-1:0]    r_bmag;
    logic [BPROD_W-1:0]  r_bprod;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_out_clip;
    logic                r_out_last;

    logic [CNT_W-1:0]    w_count_inc;
    logic [SAMPLE_W-1:0] w_amag;
    logic [PROD_W-1:0]   w_round;
    logic [MAG_W-1:0]    w_m;
    logic                w_clip;
    logic [SAMPLE_W-1:0] w_omag;
    logic [SUM_W-1:0]    w_full;
    logic                w_sat;
    logic [DIV_W-1:0]    w_quo;
    logic                w_div_done;
    logic [DIV_W-1:0]    w_rem_init;
    logic [DIV_W-1:0]    w_dividend;
    logic [DIV_W-1:0]    w_divisor;
    logic [DCNT_W-1:0]   w_steps;
    logic [GAIN_W:0]     w_gain_up;
    logic [GAIN_W-1:0]   w_gain_rec;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_limit <= LIMIT_RESET;
            r_rate       <= RATE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLIP_LIMIT:    r_clip_limit <= i_cfg_data;
                CFG_RECOVERY_RATE: r_rate       <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample magnitude; the most negative sample maps to 2^23, which still fits.
    assign w_amag      = i_in_data[SAMPLE_W-1] ? SAMPLE_W'(-i_in_data) : i_in_data;
    assign w_count_inc = r_count + 1'b1;

    // Round half up on the magnitude, then compare with the limit.
    assign w_round = r_prod + ROUND_HALF;
    assign w_m     = w_round[PROD_W-1:GFRAC_W];
    assign w_clip  = (w_m > MAG_W'(r_clip_limit));
    assign w_omag  = w_clip ? SAMPLE_W'(r_clip_limit) : w_m[SAMPLE_W-1:0];

    // Quotient gain * 2^20 / m reaches 2^24 exactly when gain >= 16 * m.
    assign w_sat = ({(MAG_W + 4 - GAIN_W)'(0), r_gain} >= {r_m, 4'b0000});

    // One full-scale level per sample of the block.
    assign w_full = {(SUM_W - CNT_W - FRAC_W)'(0), w_count_inc, FRAC_W'(0)};

    // Divider operands: clip divides gain << 20 by m, recovery divides by the block length.
    always_comb begin
        if (i_cmd.clip_load) begin
            w_rem_init = DIV_W'(r_gain[GAIN_W-1:GAIN_W-FRAC_W]);
            w_dividend = {r_gain[GAIN_W-FRAC_W-1:0], (DIV_W - GAIN_W + FRAC_W)'(0)};
            w_divisor  = r_m;
            w_steps    = CLIP_STEPS;
        end else begin
            w_rem_init = '0;
            w_dividend = r_bprod[BPROD_W-1:FRAC_W];
            w_divisor  = DIV_W'(w_count_inc);
            w_steps    = BLOCK_STEPS;
        end
    end

    dvn_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.clip_load | i_cmd.bload),
        .i_step     (i_cmd.div_step),
        .i_rem_init (w_rem_init),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // Recovered gain, saturated at both ends.
    assign w_gain_up = {1'b0, r_gain} + (GAIN_W + 1)'(w_quo);
    always_comb begin
        if (r_bneg) begin
            w_gain_rec = (w_quo >= DIV_W'(r_gain)) ? '0 : GAIN_W'(r_gain - w_quo[GAIN_W-1:0]);
        end else if (w_quo > DIV_W'(GAIN_MAX) || w_gain_up[GAIN_W]) begin
            w_gain_rec = GAIN_MAX;
        end else begin
            w_gain_rec = w_gain_up[GAIN_W-1:0];
        end
    end

    // Persistent state: gain, level sum and block count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_level_sum <= '0;
            r_count     <= '0;
        end else begin
            if (i_cmd.scale) begin
                if (!w_clip) begin
                    r_level_sum <= r_level_sum + SUM_W'(w_m);
                end
                if (!r_end) begin
                    r_count <= w_count_inc;
                end
            end
            if (i_cmd.clip_sat) begin
                r_gain <= GAIN_MAX;
            end else if (i_cmd.clip_upd) begin
                r_gain <= w_quo[GAIN_W-1:0];
            end else if (i_cmd.bupd) begin
                r_gain      <= w_gain_rec;
                r_level_sum <= '0;
                r_count     <= '0;
            end
        end
    end

    // Per-sample working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_neg  <= i_in_data[SAMPLE_W-1];
            r_amag <= w_amag;
            r_last <= i_in_last;
            r_end  <= i_in_last || (w_count_inc >= CNT_W'(MAX_BLOCK));
        end
        if (i_cmd.mul) begin
            r_prod <= r_amag * r_gain;
        end
        if (i_cmd.scale) begin
            r_m       <= w_m;
            r_clipped <= w_clip;
            r_res     <= r_neg ? SAMPLE_W'(-w_omag) : w_omag;
        end
        if (i_cmd.bmag) begin
            r_bneg <= (r_level_sum > w_full);
            r_bmag <= (r_level_sum > w_full) ? (r_level_sum - w_full) : (w_full - r_level_sum);
        end
        if (i_cmd.bmul) begin
            r_bprod <= r_bmag * r_rate;
        end
    end

    // Output register: holds a beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= r_res;
            r_out_clip <= r_clipped;
            r_out_last <= r_last;
        end
    end

    assign o_status.clipped  = r_clipped;
    assign o_status.sat      = w_sat;
    assign o_status.blk_end  = r_end;
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_clip  = r_out_clip;
    assign o_out_last  = r_out_last;

endmodule

/* src/dynamic_volume_normalizer.sv */
// Top level of the dynamic volume normalizer: controller plus datapath.
//
// Usage: audio samples (signed Q3.20) arrive on the s_axis stream, one per beat,
// with s_axis_tlast marking the last sample of a block. Each sample is scaled by a
// running Q8.16 gain and leaves on the m_axis stream; a sample whose scaled
// magnitude exceeds the clip limit is clipped, flagged in m_axis_tuser, and sets
// the gain to 1.0 over its raw magnitude. At each block end (or after 4096 samples)
// the gain recovers by the recovery rate times the gap between full scale and the
// mean unclipped level. Registers are written through i_cfg_* while idle.
//
// Sequence: a sample is captured, multiplied by the gain, scaled and clip-checked,
// then loaded into the output register once that is free. A clipped sample whose
// new gain fits adds a serial division for the 24-bit gain quotient; a block end
// adds the level error times the rate and a division by the block length on the
// same divider. A sample is taken only once the last one is in the output register.
// Reset restores gain 1.0, clip limit 1.0 and rate 655 and clears the block.
// While the receiver stalls, the output register holds its beat and the next
// sample is still taken and processed; it then waits until the register frees.
module dynamic_volume_normalizer
    import dvn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [23:0] sample_in
    input  logic                s_axis_tlast,   // block_end
    // Output stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [23:0] sample_out
    output logic [0:0]          m_axis_tuser,   // [0] was_clipped
    output logic                m_axis_tlast    // block_last
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_clip;

    dvn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    dvn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_clip  (w_clip),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser[0] = w_clip;

endmodule

/* tb/tb_dynamic_volume_normalizer.sv */
// Self-checking testbench of the dynamic volume normalizer with a built-in gain predictor.
module tb_dynamic_volume_normalizer;
    import dvn_pkg::*;

    localparam int RUN_LIMIT     = 1000000;  // cycles before the run is declared hung
    localparam int SETTLE_CYCLES = 70;       // worst case sample latency plus margin
    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int PHASE_BEATS   = 92;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
        logic                last;
    } t_beat_out;

    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        t_cfg_idx            reg_idx;
        logic [CFG_W-1:0]    value;
        logic [SAMPLE_W-1:0] sample;
        logic                eob;
        logic                typed;
        logic [SAMPLE_W-1:0] want_sample;
        logic                want_clip;
    } t_step_row;

    localparam int N_ROWS = 23;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [SAMPLE_W-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;
    logic                m_axis_tlast;

    // Predictor state and its copy of the registers.
    logic [GAIN_W-1:0]  gain_q;
    logic [SUM_W-1:0]   level_acc;
    logic [CNT_W-1:0]   blk_count;
    logic [LIMIT_W-1:0] limit_q;
    logic [RATE_W-1:0]  rate_q;

    t_beat_out pending_out[$];
    t_step_row steps [N_ROWS];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    logic hold_wanted = 1'b0;
    logic hold_done = 1'b0;

    int cycle_count = 0;
    int n_mismatch = 0;
    int n_samples = 0;
    int n_blocks = 0;
    int n_forced = 0;
    int n_cfg = 0;
    int n_checked = 0;
    int n_clipped = 0;

    dynamic_volume_normalizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [23:0] sample_in
        .s_axis_tlast  (s_axis_tlast),    // block_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [23:0] sample_out
        .m_axis_tuser  (m_axis_tuser),    // [0] was_clipped
        .m_axis_tlast  (m_axis_tlast)     // block_last
    );

    always #1 i_clk = ~i_clk;

    // Clamp a wide gain value to the top of the Q8.16 range.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [63:0] v);
        return (v > 64'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(v);
    endfunction

    // Scale one sample by the running gain, clip it, and apply the block-end recovery.
    function automatic t_beat_out scale_sample(input logic [SAMPLE_W-1:0] raw, input logic eob);
        t_beat_out   res;
        logic [63:0] amag;
        logic [63:0] m;
        logic [63:0] omag;
        logic [63:0] full;
        logic [63:0] err;
        logic [63:0] delta;
        logic        over;
        amag = raw[SAMPLE_W-1] ? (64'd1 << SAMPLE_W) - 64'(raw) : 64'(raw);
        m    = (amag * 64'(gain_q) + 64'd32768) >> GFRAC_W;
        over = m > 64'(limit_q);
        if (over) begin
            omag   = 64'(limit_q);
            gain_q = clamp_gain((64'(gain_q) << FRAC_W) / m);
        end else begin
            omag      = m;
            level_acc = SUM_W'(64'(level_acc) + m);
        end
        res.sample  = raw[SAMPLE_W-1] ? SAMPLE_W'(64'd0 - omag) : SAMPLE_W'(omag);
        res.clipped = over;
        res.last    = eob;

        // A block ends on the marked sample or when it reaches its maximum length.
        if (eob || 64'(blk_count) + 64'd1 >= 64'(MAX_BLOCK)) begin
            if (!eob) n_forced++;
            full = (64'(blk_count) + 64'd1) << FRAC_W;
            if (64'(level_acc) > full) begin
                err    = 64'(level_acc) - full;
                delta  = err * 64'(rate_q) / full;
                gain_q = (delta >= 64'(gain_q)) ? '0 : GAIN_W'(64'(gain_q) - delta);
            end else begin
                err    = full - 64'(level_acc);
                delta  = err * 64'(rate_q) / full;
                gain_q = clamp_gain(64'(gain_q) + delta);
            end
            level_acc = '0;
            blk_count = '0;
        end else begin
            blk_count = blk_count + 1'b1;
        end
        return res;
    endfunction

    // Mostly random samples, with zero, the extremes and values near full scale mixed in.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] mag;
        mag = SAMPLE_W'($urandom_range(0, 24'h180000));
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3, 4, 5: return $urandom_range(0, 1) ? -mag : mag;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: %s", msg);
    endtask

    // Offer one sample beat, with random gaps, and queue its expected result on acceptance.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] value, input logic eob,
                                input logic typed, input t_beat_out typed_out);
        t_beat_out model_out;
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_out = scale_sample(value, eob);
        pending_out.push_back(typed ? typed_out : model_out);
        n_samples++;
        if (eob) n_blocks++;
    endtask

    // Stop offering and wait until every expected beat has come out.
    task automatic drain_pipeline();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only once the block has gone idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_CLIP_LIMIT) limit_q = value[LIMIT_W-1:0];
        else rate_q = value[RATE_W-1:0];
        n_cfg++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Compare every output beat with the oldest expectation.
    always @(posedge i_clk) begin : out_check
        t_beat_out got;
        t_beat_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sample  = m_axis_tdata;
            got.clipped = m_axis_tuser[0];
            got.last    = m_axis_tlast;
            if (pending_out.size() == 0) begin
                flag_error($sformatf("unexpected beat: sample %h clip %b last %b",
                                     got.sample, got.clipped, got.last));
            end else begin
                want = pending_out.pop_front();
                n_checked++;
                if (got.clipped) n_clipped++;
                if (got.sample !== want.sample || got.clipped !== want.clipped
                        || got.last !== want.last) begin
                    flag_error($sformatf(
                        "beat %0d: sample %h/%h clip %b/%b last %b/%b (expected/actual)",
                        n_checked, want.sample, got.sample, want.clipped, got.clipped,
                        want.last, got.last));
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_step_row row;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_CLIP_LIMIT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        gain_q        = GAIN_RESET;
        level_acc     = '0;
        blk_count     = '0;
        limit_q       = LIMIT_RESET;
        rate_q        = RATE_RESET;

        // Directed rows: register writes and samples, some with hand-computed results.
        steps = '{
            // Widest limit and fastest recovery.
            '{ROW_CFG,  CFG_CLIP_LIMIT,    23'd8388607, 24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_CFG,  CFG_RECOVERY_RATE, 23'd32768,   24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            // Full scale at unity gain sits exactly on the limit.
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
            // A loud block pulls the gain down to zero.
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h800001, 1'b1, 1'b1, 24'h800001, 1'b0},
            // Zero gain gives silence, then recovery by the whole rate.
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h7FFFFF, 1'b1, 1'b1, 24'h000000, 1'b0},
            // Zero limit clips every nonzero magnitude; the gain saturates high.
            '{ROW_CFG,  CFG_CLIP_LIMIT,    23'd0,       24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h000001, 1'b0, 1'b1, 24'h000000, 1'b1},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'hFFFFFF, 1'b1, 1'b1, 24'h000000, 1'b1},
            // Zero rate leaves the gain alone at block end.
            '{ROW_CFG,  CFG_CLIP_LIMIT,    23'd1048576, 24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_CFG,  CFG_RECOVERY_RATE, 23'd0,       24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h000010, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h100000, 1'b0, 1'b1, 24'h100000, 1'b1},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h080000, 1'b1, 1'b0, 24'h0, 1'b0},
            // Smallest legal limit and rate.
            '{ROW_CFG,  CFG_CLIP_LIMIT,    23'd1,       24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_CFG,  CFG_RECOVERY_RATE, 23'd66,      24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'hF00000, 1'b0, 1'b1, 24'hFFFFFF, 1'b1},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h000001, 1'b1, 1'b0, 24'h0, 1'b0},
            // Back to the reset settings.
            '{ROW_CFG,  CFG_CLIP_LIMIT,    23'd1048576, 24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_CFG,  CFG_RECOVERY_RATE, 23'd655,     24'h000000, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'h123456, 1'b0, 1'b0, 24'h0, 1'b0},
            '{ROW_BEAT, CFG_CLIP_LIMIT,    23'd0,       24'hEDCBA9, 1'b1, 1'b0, 24'h0, 1'b0}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            row = steps[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_idx, row.value);
            end else begin
                offer_sample(row.sample, row.eob, row.typed,
                             '{row.want_sample, row.want_clip, row.eob});
            end
        end

        // Random phases: sender-light then receiver-light idling, then none.
        for (int phase = 0; phase < 6; phase++) begin
            src_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 70 : 0;
            snk_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 12 : 0;
            case (phase)
                0: begin
                    write_reg(CFG_CLIP_LIMIT, 23'd8388607);
                    write_reg(CFG_RECOVERY_RATE, 23'd66);
                end
                1: begin
                    write_reg(CFG_CLIP_LIMIT, 23'd1);
                    write_reg(CFG_RECOVERY_RATE, 23'd32768);
                end
                default: begin
                    write_reg(CFG_CLIP_LIMIT, CFG_W'($urandom_range(1, 8388607)));
                    write_reg(CFG_RECOVERY_RATE, CFG_W'($urandom_range(66, 32768)));
                end
            endcase
            // The receiver holds off for a long stretch while samples keep coming.
            if (phase == 4) hold_wanted = 1'b1;
            repeat (PHASE_BEATS) offer_sample(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, '0);
        end

        drain_pipeline();

        $display("Covered %0d samples in %0d marked blocks and %0d length-limited ones,",
                 n_samples, n_blocks, n_forced);
        $display("%0d register writes; checked %0d output beats, %0d clipped, %0d mismatches.",
                 n_cfg, n_checked, n_clipped, n_mismatch);
        if (n_mismatch == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/dvn_pkg.sv
src/dvn_divider.sv
src/dvn_ctrl.sv
src/dvn_datapath.sv
src/dynamic_volume_normalizer.sv
tb/tb_dynamic_volume_normalizer.sv
